// File: hdl/sh24_pkg.sv
`default_nettype none

package sh24_pkg;

   // Round counts and the finalization pipeline split
   localparam int COMPRESS_ROUNDS  = 2;
   localparam int FINAL_ROUNDS     = 4;
   localparam int ROUNDS_PER_STAGE = 2;
   localparam int FIN_STAGES       = (FINAL_ROUNDS + ROUNDS_PER_STAGE - 1) / ROUNDS_PER_STAGE;

   localparam logic [63:0] INIT_A  = 64'h736f6d6570736575;
   localparam logic [63:0] INIT_B  = 64'h646f72616e646f6d;
   localparam logic [63:0] INIT_C  = 64'h6c7967656e657261;
   localparam logic [63:0] INIT_D  = 64'h7465646279746573;
   localparam logic [63:0] FIN_XOR = 64'h00000000000000ff;

   localparam int CSR_ADDR_W = 4;

   typedef struct packed {
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      logic [63:0] d;
   } lanes_type;

   function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned n);
      return (x << n) | (x >> (64 - n));
   endfunction

   function automatic lanes_type sip_round(input lanes_type s);
      lanes_type t;
      t   = s;
      t.a = t.a + t.b;
      t.b = rotl64(t.b, 13);
      t.b = t.b ^ t.a;
      t.a = rotl64(t.a, 32);
      t.c = t.c + t.d;
      t.d = rotl64(t.d, 16);
      t.d = t.d ^ t.c;
      t.a = t.a + t.d;
      t.d = rotl64(t.d, 21);
      t.d = t.d ^ t.a;
      t.c = t.c + t.b;
      t.b = rotl64(t.b, 17);
      t.b = t.b ^ t.c;
      t.c = rotl64(t.c, 32);
      return t;
   endfunction

   // One message block: inject into d, compression rounds, inject into a
   function automatic lanes_type sip_absorb(input lanes_type s, input logic [63:0] m);
      lanes_type t;
      t   = s;
      t.d = t.d ^ m;
      for (int r = 0; r < COMPRESS_ROUNDS; r++) begin
         t = sip_round(t);
      end
      t.a = t.a ^ m;
      return t;
   endfunction

   function automatic lanes_type sip_seed(input logic [63:0] k0, input logic [63:0] k1);
      lanes_type t;
      t.a = INIT_A ^ k0;
      t.b = INIT_B ^ k1;
      t.c = INIT_C ^ k0;
      t.d = INIT_D ^ k1;
      return t;
   endfunction

endpackage

`default_nettype wire

// File: hdl/siphash_2_4_keyed_hash_top.sv
`default_nettype none

// SipHash-2-4 keyed hash, 64-bit result. Load the 128-bit key through the
// CSR port (key_low at 0x0, key_high at 0x8, 64-bit data) while the block is
// idle. Stream a message as 64-bit little-endian words on req_*, one
// transaction per cycle while req_tready is high; req_tlast marks the final
// word and req_tuser gives its valid byte count (0..8, larger values act as
// 8; ignored on words that are not last, which always count as 8 bytes). One
// hash comes out on rsp_* per message. Throughput is one word per cycle while
// req_tready is high: the only feedback path is the two compression rounds on
// the lane registers, done combinationally. The final block and the four
// finalization rounds run in a pipeline of 1 + ceil(FINAL_ROUNDS/2) stages
// plus the result register. The next message may start in the very next
// cycle. rsp back-pressure stalls the finalization pipeline and, once it is
// full, req_tready.
module siphash_2_4_keyed_hash_top (
   input  wire         clock,
   input  wire         reset,
   // request stream
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,    // [63:0] word
   input  wire  [3:0]  req_tuser,    // [3:0] byte_count
   input  wire         req_tlast,
   // result stream
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,    // [63:0] hash
   // CSR port
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [sh24_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire  [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import sh24_pkg::*;

   logic [63:0] key_low;
   logic [63:0] key_high;
   logic        req_accept;
   lanes_type   fin_lanes;
   logic [63:0] fin_block;

   assign req_accept = req_tvalid & req_tready;

   sh24_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (csr_psel),
      .penable  (csr_penable),
      .pwrite   (csr_pwrite),
      .paddr    (csr_paddr),
      .pwdata   (csr_pwdata),
      .prdata   (csr_prdata),
      .pready   (csr_pready),
      .key_low  (key_low),
      .key_high (key_high)
   );

   // Seeding, full-word absorb and final-block build; holds the lane state
   sh24_absorb u_absorb (
      .clock      (clock),
      .reset      (reset),
      .key_low    (key_low),
      .key_high   (key_high),
      .accept     (req_accept),
      .word       (req_tdata),
      .byte_count (req_tuser),
      .last       (req_tlast),
      .fin_lanes  (fin_lanes),
      .fin_block  (fin_block)
   );

   // Only the last word of a message enters finalization
   sh24_final u_final (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept & req_tlast),
      .in_ready  (req_tready),
      .in_lanes  (fin_lanes),
      .in_block  (fin_block),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_hash  (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: hdl/sh24_csr.sv
`default_nettype none

module sh24_csr (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 psel,
   input  wire                                 penable,
   input  wire                                 pwrite,
   input  wire  [sh24_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire  [63:0]                         pwdata,
   output logic [63:0]                         prdata,
   output logic                                pready,
   output logic [63:0]                         key_low,
   output logic [63:0]                         key_high
);
   import sh24_pkg::*;

   // 64-bit registers on an 8-byte stride; bit 3 selects the register
   localparam logic KEY_LOW_SEL  = 1'b0;
   localparam logic KEY_HIGH_SEL = 1'b1;

   logic [63:0] key_low_ff;
   logic [63:0] key_high_ff;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else if (wr_en) begin
         unique case (paddr[3])
            KEY_LOW_SEL:  key_low_ff  <= pwdata;
            KEY_HIGH_SEL: key_high_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3])
         KEY_LOW_SEL:  prdata = key_low_ff;
         KEY_HIGH_SEL: prdata = key_high_ff;
         default:      prdata = '0;
      endcase
   end

   assign key_low  = key_low_ff;
   assign key_high = key_high_ff;

endmodule

`default_nettype wire

// File: hdl/sh24_absorb.sv
`default_nettype none

module sh24_absorb (
   input  wire                     clock,
   input  wire                     reset,
   input  wire  [63:0]             key_low,
   input  wire  [63:0]             key_high,
   input  wire                     accept,
   input  wire  [63:0]             word,
   input  wire  [3:0]              byte_count,
   input  wire                     last,
   output sh24_pkg::lanes_type     fin_lanes,
   output logic [63:0]             fin_block
);
   import sh24_pkg::*;

   lanes_type   lanes_ff;
   lanes_type   lanes_in;
   lanes_type   start_lanes;
   logic [7:0]  len_ff;
   logic [7:0]  len_in;
   logic [7:0]  len_base;
   logic        start_ff;
   logic [3:0]  cnt;
   logic        full_word;
   logic [55:0] tail;

   always_comb begin
      cnt         = (byte_count > 4'd8) ? 4'd8 : byte_count;
      start_lanes = start_ff ? sip_seed(key_low, key_high) : lanes_ff;
      len_base    = start_ff ? 8'd0 : len_ff;
      full_word   = !last || (cnt == 4'd8);
      lanes_in    = full_word ? sip_absorb(start_lanes, word) : start_lanes;
      len_in      = len_base + (last ? {4'd0, cnt} : 8'd8);
      // tail bytes below the count; none when the count is 8
      for (int i = 0; i < 7; i++) begin
         tail[i*8 +: 8] = (4'(i) < cnt && cnt != 4'd8) ? word[i*8 +: 8] : 8'd0;
      end
   end

   assign fin_lanes = lanes_in;
   assign fin_block = {len_in, tail};

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b1;
         len_ff   <= '0;
      end else if (accept) begin
         start_ff <= last;
         len_ff   <= last ? 8'd0 : len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !last) begin
         lanes_ff <= lanes_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/sh24_final.sv
`default_nettype none

module sh24_final (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_valid,
   output logic                    in_ready,
   input  sh24_pkg::lanes_type     in_lanes,
   input  wire  [63:0]             in_block,
   output logic                    out_valid,
   input  wire                     out_ready,
   output logic [63:0]             out_hash
);
   import sh24_pkg::*;

   // stage 0 holds lanes + final block, stage 1 the absorbed block,
   // later stages the finalization round groups
   localparam int NS = FIN_STAGES + 1;

   logic [NS-1:0] st_v_ff;
   lanes_type     st_lanes_ff [NS];
   lanes_type     adv         [NS];
   logic [63:0]   block_ff;
   logic          hash_v_ff;
   logic [63:0]   hash_ff;
   logic [NS:0]   rdy;

   always_comb begin
      rdy[NS] = !hash_v_ff || out_ready;
      for (int j = NS - 1; j >= 0; j--) begin
         rdy[j] = !st_v_ff[j] || rdy[j+1];
      end
   end

   always_comb begin
      for (int j = 0; j < NS; j++) begin
         if (j == 0) begin
            adv[j]   = sip_absorb(st_lanes_ff[j], block_ff);
            adv[j].c = adv[j].c ^ FIN_XOR;
         end else begin
            adv[j] = st_lanes_ff[j];
            for (int r = 0; r < ROUNDS_PER_STAGE; r++) begin
               if ((j - 1) * ROUNDS_PER_STAGE + r < FINAL_ROUNDS) begin
                  adv[j] = sip_round(adv[j]);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_v_ff   <= '0;
         hash_v_ff <= 1'b0;
      end else begin
         if (rdy[0]) begin
            st_v_ff[0] <= in_valid;
         end
         for (int j = 1; j < NS; j++) begin
            if (rdy[j]) begin
               st_v_ff[j] <= st_v_ff[j-1];
            end
         end
         if (rdy[NS]) begin
            hash_v_ff <= st_v_ff[NS-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid) begin
         st_lanes_ff[0] <= in_lanes;
         block_ff       <= in_block;
      end
      for (int j = 1; j < NS; j++) begin
         if (rdy[j] && st_v_ff[j-1]) begin
            st_lanes_ff[j] <= adv[j-1];
         end
      end
      if (rdy[NS] && st_v_ff[NS-1]) begin
         hash_ff <= adv[NS-1].a ^ adv[NS-1].b ^ adv[NS-1].c ^ adv[NS-1].d;
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = hash_v_ff;
   assign out_hash  = hash_ff;

endmodule

`default_nettype wire

// File: test/tb_siphash_2_4_keyed_hash_top.sv
`default_nettype none

module tb_siphash_2_4_keyed_hash_top;

   // Round counts and lane seeds of the algorithm
   localparam int unsigned COMPRESS_ROUNDS = 2;
   localparam int unsigned FINAL_ROUNDS    = 4;
   localparam logic [63:0] SEED_A   = 64'h736f6d6570736575;
   localparam logic [63:0] SEED_B   = 64'h646f72616e646f6d;
   localparam logic [63:0] SEED_C   = 64'h6c7967656e657261;
   localparam logic [63:0] SEED_D   = 64'h7465646279746573;
   localparam logic [63:0] FIN_MARK = 64'h00000000000000ff;

   // CSR map: 64-bit registers, 8 bytes apart
   localparam logic [3:0] ADDR_KEY_LOW  = 4'h0;
   localparam logic [3:0] ADDR_KEY_HIGH = 4'h8;

   localparam int unsigned RESET_CYCLES = 6;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned HOLD_CYCLES  = 300;  // one long rsp hold-off
   localparam int unsigned PHASE_ITEMS  = 215;
   localparam int unsigned NUM_PHASES   = 7;    // phase 0 is the directed table
   localparam int unsigned PRESSURE_PHASE = 4;
   localparam int unsigned STEADY_PHASE   = 5;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DIR_ROWS     = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // [63:0] word
   logic [3:0]  req_tuser  = '0;   // [3:0] byte_count
   logic        req_tlast  = 1'b0;

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // [63:0] hash

   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [63:0] csr_pwdata  = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   siphash_2_4_keyed_hash_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Hash predictor: own copy of the four lanes, running length byte and key
   // ---------------------------------------------------------------------
   typedef struct packed {
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      logic [63:0] d;
   } sip_lanes_t;

   sip_lanes_t  lanes;
   logic [7:0]  msg_len   = '0;
   bit          msg_open  = 1'b0;   // lanes seeded, message in flight
   logic [63:0] key_lo    = '0;     // reset value of both key registers
   logic [63:0] key_hi    = '0;
   logic [63:0] pending_hashes [$];

   int unsigned fails = 0;
   int unsigned words_in = 0;
   int unsigned messages_in = 0;
   int unsigned hashes_ok = 0;
   int unsigned in_stall_cycles = 0;
   int unsigned key_settings = 1;
   int unsigned longest_msg = 0;
   int unsigned cycles = 0;
   logic [63:0] hash_want;

   bit tx_steady = 1'b0;   // sender offers back to back
   bit rx_steady = 1'b0;   // receiver always ready
   bit hold_rsp  = 1'b0;   // request for the long hold-off

   function automatic logic [63:0] rot_left(input logic [63:0] x, input int unsigned n);
      return (x << n) | (x >> (64 - n));
   endfunction

   function automatic sip_lanes_t sip_mix(input sip_lanes_t s);
      sip_lanes_t t;
      t   = s;
      t.a = t.a + t.b;
      t.b = rot_left(t.b, 13) ^ t.a;
      t.a = rot_left(t.a, 32);
      t.c = t.c + t.d;
      t.d = rot_left(t.d, 16) ^ t.c;
      t.a = t.a + t.d;
      t.d = rot_left(t.d, 21) ^ t.a;
      t.c = t.c + t.b;
      t.b = rot_left(t.b, 17) ^ t.c;
      t.c = rot_left(t.c, 32);
      return t;
   endfunction

   // One block into the lanes: xor into d, compression rounds, xor into a
   function automatic sip_lanes_t sip_inject(input sip_lanes_t s, input logic [63:0] m);
      sip_lanes_t t;
      t   = s;
      t.d = t.d ^ m;
      for (int unsigned r = 0; r < COMPRESS_ROUNDS; r++) begin
         t = sip_mix(t);
      end
      t.a = t.a ^ m;
      return t;
   endfunction

   // Called for every accepted request transaction; queues a hash on the last word
   task automatic fold_word(input logic [63:0] w, input logic [3:0] cnt, input bit lst);
      logic [63:0] tail;
      logic [3:0]  n;
      sip_lanes_t  f;
      if (!msg_open) begin
         // key is latched here, later key writes wait for the next message
         lanes.a  = SEED_A ^ key_lo;
         lanes.b  = SEED_B ^ key_hi;
         lanes.c  = SEED_C ^ key_lo;
         lanes.d  = SEED_D ^ key_hi;
         msg_len  = '0;
         msg_open = 1'b1;
      end
      if (!lst) begin
         // inner words always count as 8 bytes, byte count ignored
         lanes   = sip_inject(lanes, w);
         msg_len = msg_len + 8'd8;
      end else begin
         n    = (cnt > 4'd8) ? 4'd8 : cnt;
         tail = '0;
         if (n == 4'd8) begin
            lanes = sip_inject(lanes, w);
         end else if (n != 4'd0) begin
            tail = w & ((64'd1 << (8 * n)) - 64'd1);
         end
         msg_len       = msg_len + {4'd0, n};
         tail[63:56]   = msg_len;
         f             = sip_inject(lanes, tail);
         f.c           = f.c ^ FIN_MARK;
         for (int unsigned r = 0; r < FINAL_ROUNDS; r++) begin
            f = sip_mix(f);
         end
         pending_hashes.push_back(f.a ^ f.b ^ f.c ^ f.d);
         msg_open = 1'b0;
         messages_in++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Monitors: sampled at the rising edge, before the block's outputs move
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            fold_word(req_tdata, req_tuser, req_tlast);
            words_in++;
         end else if (req_tvalid) begin
            in_stall_cycles++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_hashes.size() == 0) begin
               $display("%0t: hash %h arrived with no message pending", $time, rsp_tdata);
               fails++;
            end else begin
               hash_want = pending_hashes.pop_front();
               if (rsp_tdata !== hash_want) begin
                  $display("%0t: hash mismatch, expected %h actual %h",
                           $time, hash_want, rsp_tdata);
                  fails++;
               end else begin
                  hashes_ok++;
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d hashes still pending",
                  $time, cycles, pending_hashes.size());
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Result side pacing: random ready pattern, always-ready stretch, and the
   // long hold-off that lets the finalization pipe fill and stall req_tready
   // ---------------------------------------------------------------------
   initial begin : rsp_pacer
      int unsigned span;
      int unsigned r;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            span       = HOLD_CYCLES;
            hold_rsp   = 1'b0;
         end else if (rx_steady) begin
            rsp_tready <= 1'b1;
            span       = 1;
         end else begin
            r = $urandom_range(0, 19);
            if (r < 12) begin
               rsp_tready <= 1'b1;
               span       = $urandom_range(1, 8);
            end else if (r < 19) begin
               rsp_tready <= 1'b0;
               span       = $urandom_range(1, 3);
            end else begin
               rsp_tready <= 1'b0;
               span       = $urandom_range(10, 40);
            end
         end
         repeat (span) @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Request side driving; every task is entered and left at a falling edge
   // ---------------------------------------------------------------------
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 19) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // Offer one word, hold it until the transaction completes
   task automatic push_word(input logic [63:0] w, input logic [3:0] cnt, input bit lst);
      int unsigned gap;
      gap = tx_steady ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tuser  <= cnt;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Random message; last word mostly with a legal count, sometimes 9..15
   task automatic send_message(input int unsigned nwords);
      logic [3:0] cnt;
      for (int unsigned k = 1; k <= nwords; k++) begin
         if (k < nwords) begin
            push_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
         end else begin
            cnt = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(0, 8));
            push_word(rand_word(), cnt, 1'b1);
         end
      end
      if (nwords > longest_msg) longest_msg = nwords;
   endtask

   // Mostly short messages, some medium, a few long enough to wrap the length byte
   function automatic int unsigned pick_len();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) return $urandom_range(30, 40);
      if (r < 5)  return $urandom_range(5, 12);
      return $urandom_range(1, 4);
   endfunction

   // Drop valid, wait for every queued hash, then let the pipe empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_hashes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // CSR access: setup cycle, then access cycle closed by pready
   // ---------------------------------------------------------------------
   task automatic csr_write(input logic [3:0] addr, input logic [63:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_KEY_LOW) key_lo = data;
      else key_hi = data;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_read(input logic [3:0] addr, output logic [63:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Write both key halves and read them back
   task automatic load_key(input logic [63:0] lo, input logic [63:0] hi);
      logic [63:0] rd;
      csr_write(ADDR_KEY_LOW, lo);
      csr_write(ADDR_KEY_HIGH, hi);
      csr_read(ADDR_KEY_LOW, rd);
      if (rd !== lo) begin
         $display("%0t: key_low readback, expected %h actual %h", $time, lo, rd);
         fails++;
      end
      csr_read(ADDR_KEY_HIGH, rd);
      if (rd !== hi) begin
         $display("%0t: key_high readback, expected %h actual %h", $time, hi, rd);
         fails++;
      end
      key_settings++;
   endtask

   // ---------------------------------------------------------------------
   // Directed table, run under the reset key (all zero). All hashes come
   // from the predictor. The table ends inside an open message so the key
   // change before the next phase hits a message in progress.
   // ---------------------------------------------------------------------
   typedef struct packed {
      logic [63:0] word;
      logic [3:0]  cnt;
      logic        lst;
   } stim_row_t;

   stim_row_t dir_rows [DIR_ROWS] = '{
      '{64'h0123456789abcdef, 4'd0,  1'b1},   // empty message, word ignored
      '{64'hffffffffffffffff, 4'd1,  1'b1},   // one byte, upper bytes masked
      '{64'hffffffffffffffff, 4'd7,  1'b1},   // seven bytes
      '{64'hffffffffffffffff, 4'd8,  1'b1},   // full last word, length-only block
      '{64'h0000000000000000, 4'd8,  1'b1},
      '{64'hfedcba9876543210, 4'd15, 1'b1},   // count saturates to 8
      '{64'h5a5a5a5a5a5a5a5a, 4'd9,  1'b1},
      '{64'h0000000000000000, 4'd3,  1'b0},   // inner word, count ignored
      '{64'hffffffffffffffff, 4'd0,  1'b1},   // empty tail after one word
      '{64'hffffffffffffffff, 4'd0,  1'b0},
      '{64'h0000000000000000, 4'd15, 1'b0},
      '{64'ha5a5a5a5a5a5a5a5, 4'd4,  1'b1},
      '{64'h0706050403020100, 4'd8,  1'b0},   // 15-byte counting pattern
      '{64'h000e0d0c0b0a0908, 4'd7,  1'b1},
      '{64'h1122334455667788, 4'd2,  1'b1},
      '{64'h8877665544332211, 4'd3,  1'b1},
      '{64'h0f1e2d3c4b5a6978, 4'd5,  1'b1},
      '{64'h8796a5b4c3d2e1f0, 4'd6,  1'b1},
      '{64'hdeadbeefcafef00d, 4'd12, 1'b0},   // open message, closed next phase
      '{64'h0badc0de01234567, 4'd1,  1'b0}
   };

   initial begin : main
      int unsigned p;
      int unsigned sent;
      int unsigned n;
      logic [63:0] klo;
      logic [63:0] khi;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int unsigned i = 0; i < DIR_ROWS; i++) begin
         push_word(dir_rows[i].word, dir_rows[i].cnt, dir_rows[i].lst);
      end
      settle();

      for (p = 1; p < NUM_PHASES; p++) begin
         case (p)
            1: begin
               klo = '1;
               khi = '1;
            end
            2: begin
               klo = 64'h0706050403020100;
               khi = 64'h0f0e0d0c0b0a0908;
            end
            3: begin
               klo = '0;
               khi = '1;
            end
            4: begin
               klo = '1;
               khi = '0;
            end
            default: begin
               klo = rand_word();
               khi = rand_word();
            end
         endcase
         load_key(klo, khi);

         // Pressure phase: back-to-back single-word messages against a held rsp
         tx_steady = (p == PRESSURE_PHASE) || (p == STEADY_PHASE);
         rx_steady = (p == STEADY_PHASE);
         if (p == PRESSURE_PHASE) hold_rsp = 1'b1;

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            n = (p == PRESSURE_PHASE) ? 1 : pick_len();
            send_message(n);
            sent += n;
         end
         settle();
         tx_steady = 1'b0;
         rx_steady = 1'b0;
      end

      $display("Covered %0d words in %0d messages under %0d keys; %0d hashes matched.",
               words_in, messages_in, key_settings, hashes_ok);
      $display("Longest message %0d words; request side stalled %0d cycles by rsp back-pressure.",
               longest_msg, in_stall_cycles);
      if (fails == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
hdl/sh24_pkg.sv
hdl/sh24_csr.sv
hdl/sh24_absorb.sv
hdl/sh24_final.sv
hdl/siphash_2_4_keyed_hash_top.sv
test/tb_siphash_2_4_keyed_hash_top.sv
